>>> sv/rbp_pkg.sv
// ----------------------------------------------------------------------------
// Ring bit packer package
// Shared constants, operation codes and the command record passed from the
// front end through the command queue to the execution back end.
// ----------------------------------------------------------------------------
package rbp_pkg;

   localparam int WORD_BITS      = 16;
   localparam int DEPTH          = 256;
   localparam int BYTES_PER_WORD = WORD_BITS / 8;
   localparam int IDX_W          = $clog2(DEPTH);
   localparam int SIZE_W         = IDX_W + 1;
   localparam int FREE_W         = $clog2(WORD_BITS);
   localparam int CNT_W          = 5;
   localparam int LEN_W          = 10;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [SIZE_W-1:0] RING_SIZE_RESET   = SIZE_W'(256);
   localparam logic [IDX_W-1:0]  START_INDEX_RESET = '0;

   typedef enum logic [1:0] {
      OP_PACK    = 2'd0,
      OP_READ    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic {
      CSR_RING_SIZE   = 1'b0,
      CSR_START_INDEX = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type                 op;
      logic [WORD_BITS-1:0]   value;
      logic [CNT_W-1:0]       bit_count;
      logic [IDX_W-1:0]       address;
   } cmd_type;

endpackage

>>> sv/rbp_front.sv
// ----------------------------------------------------------------------------
// Ring bit packer front end
// Accepts request transfers, clamps the bit count and masks the value so that
// the back end receives a ready-to-execute command.
// ----------------------------------------------------------------------------
module rbp_front
   import rbp_pkg::*;
(
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        queue_full,
   output logic        push,
   output cmd_type     cmd
);

   logic [CNT_W-1:0]     raw_count;
   logic [CNT_W-1:0]     count_clamped;
   logic [WORD_BITS:0]   value_mask;

   assign raw_count     = req_tdata[20:16];
   assign count_clamped = (raw_count > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : raw_count;
   assign value_mask    = ((WORD_BITS+1)'(1) << count_clamped) - (WORD_BITS+1)'(1);

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      cmd.op        = op_type'(req_tuser);
      cmd.value     = req_tdata[15:0] & value_mask[WORD_BITS-1:0];
      cmd.bit_count = count_clamped;
      cmd.address   = req_tdata[28:21];
   end

endmodule

>>> sv/rbp_queue.sv
// ----------------------------------------------------------------------------
// Ring bit packer command queue
// A short first-in first-out queue of commands that lets the front end keep
// accepting while the back end waits on the response side.
// ----------------------------------------------------------------------------
module rbp_queue
   import rbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> sv/rbp_back.sv
// ----------------------------------------------------------------------------
// Ring bit packer back end
// Holds the ring memory, the current partial word, the write position and the
// full flag, executes one command per unstalled cycle, registers the response.
// ----------------------------------------------------------------------------
module rbp_back
   import rbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata
);

   logic [WORD_BITS-1:0]   ring_mem [DEPTH];

   logic [SIZE_W-1:0]      ring_size_ff;
   logic [IDX_W-1:0]       start_index_ff;

   logic [IDX_W-1:0]       wr_idx_ff, wr_idx_in;
   logic [FREE_W-1:0]      free_ff, free_in;
   logic                   full_ff, full_in;
   logic [WORD_BITS-1:0]   cur_ff, cur_in;

   logic                   rsp_valid_ff;
   logic                   status_ff, status_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   is_read_ff;
   logic                   sel_cur_ff;
   logic [WORD_BITS-1:0]   cur_snap_ff;
   logic [WORD_BITS-1:0]   mem_q_ff;

   logic                   fire;
   logic [SIZE_W-1:0]      eff_size;
   logic [IDX_W-1:0]       eff_start;
   logic [CNT_W-1:0]       remaining;
   logic                   fits;
   logic [FREE_W-1:0]      free_fit;
   logic [CNT_W-1:0]       shift;
   logic [WORD_BITS-1:0]   ins_fit;
   logic [WORD_BITS-1:0]   done_word;
   logic [WORD_BITS-1:0]   new_cur;
   logic [SIZE_W-1:0]      idx_inc;
   logic [IDX_W-1:0]       idx_adv;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   logic [WORD_BITS-1:0]   mem_wd;
   logic [SIZE_W-1:0]      words;
   logic [WORD_BITS-1:0]   read_data;

   assign csr_ready = 1'b1;
   assign cmd_ready = !rsp_valid_ff || rsp_tready;
   assign fire      = cmd_valid && cmd_ready;

   assign eff_size  = (ring_size_ff < SIZE_W'(2)) ? SIZE_W'(2) :
                      (ring_size_ff > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : ring_size_ff;
   assign eff_start = ({1'b0, start_index_ff} >= eff_size) ? '0 : start_index_ff;

   assign remaining = CNT_W'(free_ff) + CNT_W'(1);
   assign fits      = cmd.bit_count < remaining;
   assign free_fit  = free_ff - FREE_W'(cmd.bit_count);
   assign shift     = cmd.bit_count - remaining;
   assign ins_fit   = WORD_BITS'({{WORD_BITS{1'b0}}, cmd.value} << (CNT_W'(free_fit) + CNT_W'(1)));
   assign done_word = cur_ff | (cmd.value >> shift);
   assign new_cur   = WORD_BITS'({{WORD_BITS{1'b0}}, cmd.value} << (CNT_W'(WORD_BITS) - shift));
   assign idx_inc   = SIZE_W'(wr_idx_ff) + SIZE_W'(1);
   assign idx_adv   = (idx_inc >= eff_size) ? '0 : idx_inc[IDX_W-1:0];

   always_comb begin
      wr_idx_in = wr_idx_ff;
      free_in   = free_ff;
      full_in   = full_ff;
      cur_in    = cur_ff;
      status_in = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = wr_idx_ff;
      mem_wd    = cur_ff;
      if (fire) begin
         unique case (cmd.op)
            OP_PACK: begin
               if (full_ff) begin
                  status_in = 1'b1;
               end else if (cmd.bit_count != '0) begin
                  if (fits) begin
                     free_in = free_fit;
                     cur_in  = cur_ff | ins_fit;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wd    = done_word;
                     free_in   = FREE_W'(WORD_BITS - 1) - FREE_W'(shift);
                     wr_idx_in = idx_adv;
                     if (idx_adv == eff_start) begin
                        full_in   = 1'b1;
                        status_in = 1'b1;
                     end else begin
                        cur_in = new_cur;
                     end
                  end
               end
            end
            OP_RESTART: begin
               mem_we    = !full_ff;
               wr_idx_in = eff_start;
               free_in   = FREE_W'(WORD_BITS - 1);
               full_in   = 1'b0;
               cur_in    = '0;
            end
            OP_READ: begin
            end
            OP_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (wr_idx_in < eff_start || full_in) begin
         words = eff_size - SIZE_W'(eff_start) + SIZE_W'(wr_idx_in);
      end else begin
         words = SIZE_W'(wr_idx_in) - SIZE_W'(eff_start);
      end
      len_in = LEN_W'(words * BYTES_PER_WORD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff   <= RING_SIZE_RESET;
         start_index_ff <= START_INDEX_RESET;
         wr_idx_ff      <= '0;
         free_ff        <= FREE_W'(WORD_BITS - 1);
         full_ff        <= 1'b0;
         cur_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_RING_SIZE) begin
            ring_size_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_START_INDEX) begin
            start_index_ff <= csr_data[IDX_W-1:0];
         end
         wr_idx_ff <= wr_idx_in;
         free_ff   <= free_in;
         full_ff   <= full_in;
         cur_ff    <= cur_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff   <= status_in;
         len_ff      <= len_in;
         is_read_ff  <= (cmd.op == OP_READ);
         sel_cur_ff  <= (cmd.address == wr_idx_ff) && !full_ff;
         cur_snap_ff <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_wa] <= mem_wd;
      end
      if (fire && cmd.op == OP_READ) begin
         mem_q_ff <= ring_mem[cmd.address];
      end
   end

   assign read_data  = !is_read_ff ? '0 : (sel_cur_ff ? cur_snap_ff : mem_q_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, len_ff, read_data, status_ff};

endmodule

>>> sv/ring_bit_packer.sv
// A request passes the command queue entry and then the back-end response register before rsp_tvalid.
// The back end takes one request per cycle while the response is not stalled.
// The two-entry command queue takes one more request transfer after a response
// stall begins, then req_tready drops until the back end moves on.
// Reset (synchronous) clears the write index, bit position, full flag and
// current word, and restores ring_size 256 and start_index 0; no clearing pass.
// ----------------------------------------------------------------------------
// Ring bit packer
// Packs variable-width bit fields, most significant bit first, into a ring of
// words and answers each request with status, read data and filled length.
// ----------------------------------------------------------------------------
module ring_bit_packer
   import rbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[15:0], bit_count[20:16], address[28:21]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // status[0], read_data[16:1], byte_length[26:17]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   logic    queue_full;
   logic    push;
   cmd_type front_cmd;
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type back_cmd;

   rbp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (front_cmd)
   );

   rbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .full      (queue_full),
      .pop_valid (cmd_valid),
      .pop_ready (cmd_ready),
      .pop_cmd   (back_cmd)
   );

   rbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> sv/rbp_checker.sv
// ----------------------------------------------------------------------------
// Ring bit packer checker
// Port-level assertions on the response stream, bound to the top level.
// ----------------------------------------------------------------------------
module rbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        csr_index,
   input logic [8:0]  csr_data
);

   // A stalled response transfer keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   // An overflow can only come from a pack, which returns no read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[16:1] == 16'd0)
      else $error("overflow response carries read data");

   // The length counts whole two-byte words.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[17] && rsp_tdata[31:27] == 5'd0)
      else $error("odd byte length or stray padding bits");

endmodule

bind ring_bit_packer rbp_checker u_rbp_checker (.*);
